// ===== design/spirv_descriptor_set_rewrite_macros.svh =====
// Assertion helpers shared by the checker files.
// Every macro samples on clk and is switched off while rst_n is low.
`ifndef SPIRV_DESCRIPTOR_SET_REWRITE_MACROS_SVH
`define SPIRV_DESCRIPTOR_SET_REWRITE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sdsr_pkg.sv =====
package sdsr_pkg;

  localparam int DEF_MODULE_WORDS = 4096;
  localparam int DEF_MAX_IDS      = 16;

  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 12;
  localparam int WORD_W     = 32;
  localparam int SIZE_W     = 15;
  localparam int STATUS_W   = 3;
  localparam int CNT_W      = 16;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  localparam logic [WORD_W-1:0] MAGIC_WORD       = 32'h0723_0203;
  localparam logic [CNT_W-1:0]  OPC_VARIABLE     = 16'd59;
  localparam logic [CNT_W-1:0]  OPC_DECORATE     = 16'd71;
  localparam logic [WORD_W-1:0] DECO_SET         = 32'd34;
  localparam logic [WORD_W-1:0] SC_UNIFORM_CONST = 32'd0;
  localparam logic [WORD_W-1:0] SC_STORAGE_BUF   = 32'd12;
  localparam logic [SIZE_W-1:0] MIN_BYTES        = 15'd20;
  localparam logic [CNT_W-1:0]  MIN_OPERAND_WORDS = 16'd4;
  localparam int                HEADER_WORDS     = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED    = 3'd0,
    ST_TOO_SMALL   = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_NO_RES      = 3'd3,
    ST_PATCHED     = 3'd4,
    ST_PATCHED_OVF = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    MEM_IDLE    = 4'd0,
    MEM_BUS_WR  = 4'd1,
    MEM_BUS_RD  = 4'd2,
    MEM_RD_ZERO = 4'd3,
    MEM_RD_HEAD = 4'd4,
    MEM_RD_OP1  = 4'd5,
    MEM_RD_OP2  = 4'd6,
    MEM_RD_OP3  = 4'd7,
    MEM_WR_OP3  = 4'd8
  } mem_op_t;

  typedef struct packed {
    mem_op_t mem_op;
    logic    start;
    logic    pos_init;
    logic    head_ld;
    logic    pos_adv;
    logic    adv_head;
    logic    id_push;
    logic    tgt_ld;
    logic    srch_next;
    logic    out_ld;
    logic    out_is_read;
    status_t out_status;
  } sdsr_cmd_t;

  typedef struct packed {
    logic too_small;
    logic magic_ok;
    logic pos_end;
    logic head_bad;
    logic is_var;
    logic is_deco;
    logic sc_ok;
    logic deco_set;
    logic id_match;
    logic srch_last;
    logic count_zero;
    logic overflow;
  } sdsr_flags_t;

endpackage

// ===== design/spirv_descriptor_set_rewrite.sv =====
// Channel  Direction  tdata (low bit up)                           tuser
// in_      slave      address[11:0] word[43:12] byte_len[58:44]    kind[1:0]
// out_     master     read_data[31:0] status[34:32]                -
//
// Write and read items are answered from the registered memory port, a read with its word in the
// cycle after it is accepted; a new item is taken as soon as the output is free.
// A start item checks the magic word, then walks the module up to twice over the single memory
// port, reading each instruction head and the operands it needs and, for each set decoration,
// searching the ID table entry by entry.
// rst_n is synchronous; memory and ID table contents are not cleared.
// in_tready drops while a walk runs or a result is stalled on the output.
module spirv_descriptor_set_rewrite #(
  parameter int MODULE_WORDS = sdsr_pkg::DEF_MODULE_WORDS,
  parameter int MAX_IDS      = sdsr_pkg::DEF_MAX_IDS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sdsr_pkg::IN_DATA_W-1:0]    in_tdata,  // address, word, byte_len
  input  logic [sdsr_pkg::KIND_W-1:0]       in_tuser,  // kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sdsr_pkg::OUT_DATA_W-1:0]   out_tdata  // read_data, status
);
  import sdsr_pkg::*;

  sdsr_cmd_t         cmd;
  sdsr_flags_t       flags;
  logic [WORD_W-1:0] dp_read_data;
  status_t           dp_status;

  sdsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .flags      (flags),
    .cmd        (cmd)
  );

  sdsr_dp #(
    .MODULE_WORDS (MODULE_WORDS),
    .MAX_IDS      (MAX_IDS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_address    (in_tdata[ADDR_W-1:0]),
    .in_word       (in_tdata[ADDR_W+WORD_W-1:ADDR_W]),
    .in_byte_len   (in_tdata[ADDR_W+WORD_W+SIZE_W-1:ADDR_W+WORD_W]),
    .cmd           (cmd),
    .flags         (flags),
    .read_data     (dp_read_data),
    .status        (dp_status)
  );

  assign out_tdata = {{(OUT_DATA_W - WORD_W - STATUS_W){1'b0}}, dp_status, dp_read_data};

endmodule

// ===== design/sdsr_dp.sv =====
module sdsr_dp #(
  parameter int MODULE_WORDS = sdsr_pkg::DEF_MODULE_WORDS,
  parameter int MAX_IDS      = sdsr_pkg::DEF_MAX_IDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sdsr_pkg::ADDR_W-1:0]   in_address,
  input  logic [sdsr_pkg::WORD_W-1:0]   in_word,
  input  logic [sdsr_pkg::SIZE_W-1:0]   in_byte_len,
  input  sdsr_pkg::sdsr_cmd_t           cmd,
  output sdsr_pkg::sdsr_flags_t         flags,
  output logic [sdsr_pkg::WORD_W-1:0]   read_data,
  output sdsr_pkg::status_t             status
);
  import sdsr_pkg::*;

  localparam int AW = $clog2(MODULE_WORDS);
  localparam int NW = $clog2(MODULE_WORDS + 1);
  localparam int SW = ((NW > CNT_W) ? NW : CNT_W) + 1;
  localparam int QW = SIZE_W - 2;
  localparam int XW = (NW > QW) ? NW : QW;
  localparam int IW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CW = $clog2(MAX_IDS + 1);

  logic [WORD_W-1:0] mem [MODULE_WORDS];
  logic [WORD_W-1:0] ids [MAX_IDS];

  logic [WORD_W-1:0] rdata_r;
  logic [WORD_W-1:0] id_rdata_r;
  logic [WORD_W-1:0] tgt_r;
  logic [NW-1:0]     nw_r;
  logic [NW-1:0]     pos_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     k_r;
  logic              ovf_r;
  logic              too_small_r;
  logic              is_read_r;
  status_t           status_r;

  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     bus_addr;
  logic [QW-1:0]     words_raw;
  logic [NW-1:0]     nw_sat;
  logic [CNT_W-1:0]  head_cnt;
  logic [CNT_W-1:0]  head_op;
  logic [CNT_W-1:0]  cnt_sel;
  logic [SW-1:0]     head_end;
  logic              id_full;
  logic [IW-1:0]     id_raddr;

  // Reduce the bus address modulo the memory depth by shifted compare-subtract steps.
  function automatic logic [AW-1:0] wrap_addr(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    r = a;
    for (int j = ADDR_W - 1; j >= 0; j--) begin
      if ((longint'(MODULE_WORDS) << j) <= longint'(r)) begin
        r = r - ADDR_W'(longint'(MODULE_WORDS) << j);
      end
    end
    return AW'(r);
  endfunction

  assign bus_addr  = wrap_addr(in_address);
  assign words_raw = in_byte_len[SIZE_W-1:2];
  assign nw_sat    = (XW'(words_raw) > XW'(MODULE_WORDS)) ? NW'(MODULE_WORDS) : NW'(words_raw);

  assign head_cnt = rdata_r[WORD_W-1:CNT_W];
  assign head_op  = rdata_r[CNT_W-1:0];
  assign head_end = SW'(pos_r) + SW'(head_cnt);
  assign cnt_sel  = cmd.adv_head ? head_cnt : cnt_r;
  assign id_full  = (count_r == CW'(MAX_IDS));
  assign id_raddr = cmd.tgt_ld ? '0 : IW'(k_r + CW'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = in_word;
    unique case (cmd.mem_op)
      MEM_IDLE: begin
      end
      MEM_BUS_WR: begin
        mem_we   = 1'b1;
        mem_addr = bus_addr;
      end
      MEM_BUS_RD: begin
        mem_re   = 1'b1;
        mem_addr = bus_addr;
      end
      MEM_RD_ZERO: begin
        mem_re   = 1'b1;
      end
      MEM_RD_HEAD: begin
        mem_re   = 1'b1;
        mem_addr = AW'(pos_r);
      end
      MEM_RD_OP1: begin
        mem_re   = 1'b1;
        mem_addr = AW'(pos_r + NW'(1));
      end
      MEM_RD_OP2: begin
        mem_re   = 1'b1;
        mem_addr = AW'(pos_r + NW'(2));
      end
      MEM_RD_OP3: begin
        mem_re   = 1'b1;
        mem_addr = AW'(pos_r + NW'(3));
      end
      MEM_WR_OP3: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(pos_r + NW'(3));
        mem_wdata = WORD_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.id_push && !id_full) begin
      ids[IW'(count_r)] <= rdata_r;
    end
    if (cmd.tgt_ld || cmd.srch_next) begin
      id_rdata_r <= ids[id_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.start) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.id_push) begin
      if (id_full) begin
        ovf_r <= 1'b1;
      end else begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      nw_r        <= nw_sat;
      too_small_r <= (in_byte_len < MIN_BYTES);
    end
    if (cmd.pos_init) begin
      pos_r <= NW'(HEADER_WORDS);
    end else if (cmd.pos_adv) begin
      // the head check guarantees the sum stays within the module length
      pos_r <= NW'(SW'(pos_r) + SW'(cnt_sel));
    end
    if (cmd.head_ld) begin
      cnt_r <= head_cnt;
    end
    if (cmd.tgt_ld) begin
      tgt_r <= rdata_r;
      k_r   <= '0;
    end else if (cmd.srch_next) begin
      k_r   <= k_r + CW'(1);
    end
    if (cmd.out_ld) begin
      status_r  <= cmd.out_status;
      is_read_r <= cmd.out_is_read;
    end
  end

  assign flags.too_small  = too_small_r;
  assign flags.magic_ok   = (rdata_r == MAGIC_WORD);
  assign flags.pos_end    = (pos_r >= nw_r);
  assign flags.head_bad   = (head_cnt == '0) || (head_end > SW'(nw_r));
  assign flags.is_var     = (head_op == OPC_VARIABLE) && (head_cnt >= MIN_OPERAND_WORDS);
  assign flags.is_deco    = (head_op == OPC_DECORATE) && (head_cnt >= MIN_OPERAND_WORDS);
  assign flags.sc_ok      = (rdata_r == SC_UNIFORM_CONST) || (rdata_r == SC_STORAGE_BUF);
  assign flags.deco_set   = (rdata_r == DECO_SET);
  assign flags.id_match   = (id_rdata_r == tgt_r);
  assign flags.srch_last  = ((CW + 1)'(k_r) + (CW + 1)'(1)) >= (CW + 1)'(count_r);
  assign flags.count_zero = (count_r == '0);
  assign flags.overflow   = ovf_r;

  assign read_data = is_read_r ? rdata_r : '0;
  assign status    = status_r;

endmodule

// ===== design/sdsr_ctrl.sv =====
module sdsr_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic [sdsr_pkg::KIND_W-1:0]   in_kind,
  output logic                          in_tready,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  sdsr_pkg::sdsr_flags_t         flags,
  output sdsr_pkg::sdsr_cmd_t           cmd
);
  import sdsr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAGIC,
    S_P1_HRD,
    S_P1_HEAD,
    S_P1_SC,
    S_P1_ID,
    S_P2_HRD,
    S_P2_HEAD,
    S_P2_DECO,
    S_P2_TGT,
    S_P2_SRCH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  status_t done_status;

  assign in_tready   = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid  = out_valid_r;
  assign done_status = flags.overflow ? ST_PATCHED_OVF : ST_PATCHED;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          unique case (in_kind)
            KIND_WRITE: begin
              cmd.mem_op     = MEM_BUS_WR;
              cmd.out_ld     = 1'b1;
              cmd.out_status = ST_ACCEPTED;
              out_valid_nxt  = 1'b1;
            end
            KIND_READ: begin
              cmd.mem_op      = MEM_BUS_RD;
              cmd.out_ld      = 1'b1;
              cmd.out_is_read = 1'b1;
              cmd.out_status  = ST_ACCEPTED;
              out_valid_nxt   = 1'b1;
            end
            KIND_START: begin
              cmd.start  = 1'b1;
              cmd.mem_op = MEM_RD_ZERO;
              state_nxt  = S_MAGIC;
            end
            default: begin
              cmd.out_ld     = 1'b1;
              cmd.out_status = ST_ACCEPTED;
              out_valid_nxt  = 1'b1;
            end
          endcase
        end
      end

      S_MAGIC: begin
        cmd.out_ld = 1'b1;
        priority if (flags.too_small) begin
          cmd.out_status = ST_TOO_SMALL;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (!flags.magic_ok) begin
          cmd.out_status = ST_BAD_MAGIC;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.out_ld   = 1'b0;
          cmd.pos_init = 1'b1;
          state_nxt    = S_P1_HRD;
        end
      end

      S_P1_HRD: begin
        if (flags.pos_end) begin
          if (flags.count_zero) begin
            cmd.out_ld     = 1'b1;
            cmd.out_status = ST_NO_RES;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.pos_init = 1'b1;
            state_nxt    = S_P2_HRD;
          end
        end else begin
          cmd.mem_op = MEM_RD_HEAD;
          state_nxt  = S_P1_HEAD;
        end
      end

      S_P1_HEAD: begin
        priority if (flags.head_bad) begin
          // malformed word count ends the pass
          if (flags.count_zero) begin
            cmd.out_ld     = 1'b1;
            cmd.out_status = ST_NO_RES;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.pos_init = 1'b1;
            state_nxt    = S_P2_HRD;
          end
        end else if (flags.is_var) begin
          cmd.head_ld = 1'b1;
          cmd.mem_op  = MEM_RD_OP3;
          state_nxt   = S_P1_SC;
        end else begin
          cmd.pos_adv  = 1'b1;
          cmd.adv_head = 1'b1;
          state_nxt    = S_P1_HRD;
        end
      end

      S_P1_SC: begin
        if (flags.sc_ok) begin
          cmd.mem_op = MEM_RD_OP2;
          state_nxt  = S_P1_ID;
        end else begin
          cmd.pos_adv = 1'b1;
          state_nxt   = S_P1_HRD;
        end
      end

      S_P1_ID: begin
        cmd.id_push = 1'b1;
        cmd.pos_adv = 1'b1;
        state_nxt   = S_P1_HRD;
      end

      S_P2_HRD: begin
        if (flags.pos_end) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = done_status;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.mem_op = MEM_RD_HEAD;
          state_nxt  = S_P2_HEAD;
        end
      end

      S_P2_HEAD: begin
        priority if (flags.head_bad) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = done_status;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (flags.is_deco) begin
          cmd.head_ld = 1'b1;
          cmd.mem_op  = MEM_RD_OP2;
          state_nxt   = S_P2_DECO;
        end else begin
          cmd.pos_adv  = 1'b1;
          cmd.adv_head = 1'b1;
          state_nxt    = S_P2_HRD;
        end
      end

      S_P2_DECO: begin
        if (flags.deco_set) begin
          cmd.mem_op = MEM_RD_OP1;
          state_nxt  = S_P2_TGT;
        end else begin
          cmd.pos_adv = 1'b1;
          state_nxt   = S_P2_HRD;
        end
      end

      S_P2_TGT: begin
        cmd.tgt_ld = 1'b1;
        state_nxt  = S_P2_SRCH;
      end

      S_P2_SRCH: begin
        priority if (flags.id_match) begin
          cmd.mem_op  = MEM_WR_OP3;
          cmd.pos_adv = 1'b1;
          state_nxt   = S_P2_HRD;
        end else if (flags.srch_last) begin
          cmd.pos_adv = 1'b1;
          state_nxt   = S_P2_HRD;
        end else begin
          cmd.srch_next = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/sdsr_checker.sv =====
`include "spirv_descriptor_set_rewrite_macros.svh"

module sdsr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [sdsr_pkg::KIND_W-1:0]       in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sdsr_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import sdsr_pkg::*;

  // stalled result must hold
  `SDSR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output changed while stalled")

  // a write transaction answers in the next cycle with zero data and status accepted
  `SDSR_ASSERT_NEXT(a_write_resp, in_tvalid && in_tready && in_tuser == KIND_WRITE, out_tvalid && out_tdata[WORD_W-1:0] == '0 && out_tdata[WORD_W+STATUS_W-1:WORD_W] == ST_ACCEPTED, "write response missing or wrong")

  // a read transaction answers in the next cycle with status accepted
  `SDSR_ASSERT_NEXT(a_read_resp, in_tvalid && in_tready && in_tuser == KIND_READ, out_tvalid && out_tdata[WORD_W+STATUS_W-1:WORD_W] == ST_ACCEPTED, "read response missing or wrong")

  // a start transaction blocks the input and shows no result in the next cycle
  `SDSR_ASSERT_NEXT(a_start_busy, in_tvalid && in_tready && in_tuser == KIND_START, !out_tvalid && !in_tready, "start did not hold off the channels")

  `SDSR_ASSERT_SAME(a_status_range, out_tvalid, out_tdata[WORD_W+STATUS_W-1:WORD_W] <= ST_PATCHED_OVF, "status code out of range")

endmodule

bind spirv_descriptor_set_rewrite sdsr_checker u_sdsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
